// ===== design/iafp_pkg.sv =====
// Package: shared constants and types for the IMU angle frame parser.
`default_nettype none

package iafp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned WordWidth   = 16;
   localparam int unsigned PosWidth    = 4;
   localparam int unsigned NumWords    = 4;
   localparam int unsigned NumData     = 2 * NumWords;
   localparam int unsigned DataIdxW    = $clog2(NumData);
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
   localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

   localparam logic [ByteWidth-1:0] HeaderByte = 8'h55;
   localparam logic [ByteWidth-1:0] TypeByte   = 8'h53;

   // Frame positions: header, type, data bytes, checksum
   localparam logic [PosWidth-1:0] PosHeader   = 4'd0;
   localparam logic [PosWidth-1:0] PosType     = 4'd1;
   localparam logic [PosWidth-1:0] PosFirstDat = 4'd2;
   localparam logic [PosWidth-1:0] PosChecksum = 4'd10;

   // One completed frame as handed from the front to the back
   typedef struct packed {
      logic                                  type_ok;
      logic                                  sum_ok;
      logic [NumData-1:0][ByteWidth-1:0]     data;
   } frame_rec_type;

   // Queue occupancy seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage : iafp_pkg

`default_nettype wire

// ===== design/iafp_front.sv =====
// Front end: accepts bytes, tracks frame position and checksum, builds frame records.
`default_nettype none

module iafp_front
   import iafp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [ByteWidth-1:0]  req_rx_byte,
   input  wire queue_status_type      queue_status,
   output logic                       req_stall,
   output logic                       push,
   output frame_rec_type              push_rec
);

   logic [PosWidth-1:0]             pos_ff, pos_in;
   logic [ByteWidth-1:0]            sum_ff, sum_in;
   logic                            type_ok_ff, type_ok_in;
   logic [NumData-1:0][ByteWidth-1:0] data_ff;
   logic [PosWidth-1:0]             pos_eff;
   logic [PosWidth-1:0]             data_off;
   logic                            accept;
   logic                            data_wr;

   // Hold the byte side off while no queue slot is free
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   // Treat an out-of-range position as the start of a frame
   assign pos_eff  = (pos_ff > PosChecksum) ? PosHeader : pos_ff;
   assign data_off = pos_eff - PosFirstDat;
   assign data_wr  = accept && (pos_eff >= PosFirstDat) && (pos_eff < PosChecksum);

   // Advance position and running sum per accepted byte
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      type_ok_in = type_ok_ff;
      push       = 1'b0;
      if (accept) begin
         if (pos_eff == PosHeader) begin
            // drop anything but the header byte while idle
            if (req_rx_byte == HeaderByte) begin
               pos_in = PosType;
               sum_in = req_rx_byte;
            end else begin
               pos_in = PosHeader;
               sum_in = 8'd0;
            end
         end else if (pos_eff == PosChecksum) begin
            push   = 1'b1;
            pos_in = PosHeader;
            sum_in = 8'd0;
         end else begin
            sum_in = sum_ff + req_rx_byte;
            pos_in = pos_eff + 4'd1;
            if (pos_eff == PosType) begin
               type_ok_in = (req_rx_byte == TypeByte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= PosHeader;
         sum_ff     <= 8'd0;
         type_ok_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         type_ok_ff <= type_ok_in;
      end
   end

   // Store the eight data bytes at their slots
   always_ff @(posedge clock) begin
      if (data_wr) begin
         data_ff[data_off[DataIdxW-1:0]] <= req_rx_byte;
      end
   end

   // Frame record pushed with the checksum byte
   always_comb begin
      push_rec.type_ok = type_ok_ff;
      push_rec.sum_ok  = (sum_ff == req_rx_byte);
      push_rec.data    = data_ff;
   end

endmodule : iafp_front

`default_nettype wire

// ===== design/iafp_queue.sv =====
// Two-entry queue of frame records between front and back.
`default_nettype none

module iafp_queue
   import iafp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire frame_rec_type     push_rec,
   input  wire logic              pop,
   output frame_rec_type          pop_rec,
   output queue_status_type       status
);

   frame_rec_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]        count_ff, count_in;
   logic                        do_push, do_pop;

   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_rec      = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule : iafp_queue

`default_nettype wire

// ===== design/iafp_back.sv =====
// Back end: checks frame records and drives the registered result stage.
`default_nettype none

module iafp_back
   import iafp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire frame_rec_type         pop_rec,
   input  wire queue_status_type      queue_status,
   output logic                       pop,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic signed [WordWidth-1:0] rsp_roll_raw,
   output logic signed [WordWidth-1:0] rsp_pitch_raw,
   output logic signed [WordWidth-1:0] rsp_yaw_raw,
   output logic signed [WordWidth-1:0] rsp_fourth_word_raw
);

   logic                              valid_ff, valid_in;
   logic [NumWords-1:0][WordWidth-1:0] word_ff;
   logic                              slot_free;
   logic                              load;

   // Take a record whenever the result register is empty or draining
   assign slot_free = !valid_ff || !rsp_stall;
   assign pop       = slot_free && !queue_status.empty;
   assign load      = pop && pop_rec.type_ok && pop_rec.sum_ok;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Assemble little-endian words from byte pairs
   always_ff @(posedge clock) begin
      if (load) begin
         for (int w = 0; w < NumWords; w++) begin
            word_ff[w] <= {pop_rec.data[2*w+1], pop_rec.data[2*w]};
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_roll_raw        = $signed(word_ff[0]);
   assign rsp_pitch_raw       = $signed(word_ff[1]);
   assign rsp_yaw_raw         = $signed(word_ff[2]);
   assign rsp_fourth_word_raw = $signed(word_ff[3]);

endmodule : iafp_back

`default_nettype wire

// ===== design/imu_angle_frame_parser_unit.sv =====
// Usage:
//   Byte channel (req_): one received serial byte per accepted item, up to one
//   per cycle. Bytes other than 0x55 are dropped while no frame is open; an
//   11-byte frame whose type byte is 0x53 and whose checksum matches yields
//   one result item on the rsp_ channel with roll, pitch, yaw and the fourth
//   word as signed 16-bit values in 0.01 degree units.
//   The result is registered: a frame record enters the record queue when the
//   checksum byte is accepted, and from there moves into the result register.
//   Throughput: one byte per cycle while req_stall is low, set by the front
//   end's position counter and running checksum, which take one byte each cycle.
//   A two-entry queue of completed frames sits between the front end and the
//   result register, so bytes keep flowing while a result waits.
//   When the receiver stalls, the result holds; once the queue is full,
//   req_stall rises and holds off further bytes until a slot frees.
//   Reset (synchronous, active high) returns to idle with no frame open,
//   clears the checksum and empties the queue; no result is valid after it.
`default_nettype none

module imu_angle_frame_parser_unit
   import iafp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ByteWidth-1:0]   req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [WordWidth-1:0] rsp_roll_raw,
   output logic signed [WordWidth-1:0] rsp_pitch_raw,
   output logic signed [WordWidth-1:0] rsp_yaw_raw,
   output logic signed [WordWidth-1:0] rsp_fourth_word_raw
);

   logic              push;
   logic              pop;
   frame_rec_type     push_rec;
   frame_rec_type     pop_rec;
   queue_status_type  queue_status;

   iafp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .queue_status (queue_status),
      .req_stall    (req_stall),
      .push         (push),
      .push_rec     (push_rec)
   );

   iafp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .status   (queue_status)
   );

   iafp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_rec             (pop_rec),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_roll_raw        (rsp_roll_raw),
      .rsp_pitch_raw       (rsp_pitch_raw),
      .rsp_yaw_raw         (rsp_yaw_raw),
      .rsp_fourth_word_raw (rsp_fourth_word_raw)
   );

   // A completed frame is never pushed into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && queue_status.full))
      else $error("frame record pushed into full queue");

   // A pushed frame is waiting in the queue on the next cycle
   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      push |=> !queue_status.empty)
      else $error("pushed frame record missing from queue");

   // No result is valid right after reset
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule : imu_angle_frame_parser_unit

`default_nettype wire

// ===== tb/imu_angle_frame_parser_unit_tb.sv =====
// Testbench for the IMU angle frame parser: directed frames and random byte streams, predicted angle words.
`default_nettype none

module imu_angle_frame_parser_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iafp_pkg::*;

   localparam int unsigned FrameLen   = 11;
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned DrainWait  = 10;

   typedef struct packed {
      logic signed [WordWidth-1:0] roll;
      logic signed [WordWidth-1:0] pitch;
      logic signed [WordWidth-1:0] yaw;
      logic signed [WordWidth-1:0] fourth;
   } angle_set_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [ByteWidth-1:0]        req_rx_byte;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [WordWidth-1:0] rsp_roll_raw;
   logic signed [WordWidth-1:0] rsp_pitch_raw;
   logic signed [WordWidth-1:0] rsp_yaw_raw;
   logic signed [WordWidth-1:0] rsp_fourth_word_raw;

   // Bytes waiting to be sent and angle sets waiting to come back
   logic [ByteWidth-1:0] pending_bytes[$];
   angle_set_type        expected_angles[$];

   // Parser state mirrored by the predictor
   logic [PosWidth-1:0]  frame_pos;
   logic [ByteWidth-1:0] frame_sum;
   logic [ByteWidth-1:0] frame_buf [FrameLen];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;
   int unsigned error_count;
   logic        req_taken;

   imu_angle_frame_parser_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_roll_raw        (rsp_roll_raw),
      .rsp_pitch_raw       (rsp_pitch_raw),
      .rsp_yaw_raw         (rsp_yaw_raw),
      .rsp_fourth_word_raw (rsp_fourth_word_raw)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Advance the frame assembly by one accepted byte; queue the angles of a good frame
   task automatic track_frame_byte(input logic [ByteWidth-1:0] b);
      angle_set_type angles;
      if (frame_pos > PosChecksum) begin
         frame_pos = PosHeader;
         frame_sum = '0;
      end
      if (frame_pos == PosHeader && b != HeaderByte) begin
         return;
      end
      frame_buf[frame_pos] = b;
      if (frame_pos < PosChecksum) begin
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 1'b1;
      end else begin
         if (frame_buf[PosType] == TypeByte && frame_sum == b) begin
            angles.roll   = {frame_buf[3], frame_buf[2]};
            angles.pitch  = {frame_buf[5], frame_buf[4]};
            angles.yaw    = {frame_buf[7], frame_buf[6]};
            angles.fourth = {frame_buf[9], frame_buf[8]};
            expected_angles.push_back(angles);
         end
         frame_pos = PosHeader;
         frame_sum = '0;
      end
   endtask

   // Queue one frame; a nonzero sum_flip corrupts the checksum
   task automatic queue_frame(input logic [ByteWidth-1:0] kind,
                              input logic [ByteWidth-1:0] data [NumData],
                              input logic [ByteWidth-1:0] sum_flip);
      logic [ByteWidth-1:0] sum;
      sum = HeaderByte + kind;
      pending_bytes.push_back(HeaderByte);
      pending_bytes.push_back(kind);
      foreach (data[i]) begin
         pending_bytes.push_back(data[i]);
         sum = sum + data[i];
      end
      pending_bytes.push_back(sum ^ sum_flip);
   endtask

   // Mostly well-formed frames with random content, some noise and broken frames
   task automatic queue_random_stream(input int unsigned n_bytes);
      logic [ByteWidth-1:0] data [NumData];
      logic [ByteWidth-1:0] kind;
      logic [ByteWidth-1:0] flip;
      int unsigned          count;
      int unsigned          pick;
      count = 0;
      while (count < n_bytes) begin
         if ($urandom_range(99) < 78) begin
            kind = ($urandom_range(99) < 88) ? TypeByte : ByteWidth'($urandom);
            foreach (data[i]) begin
               pick = $urandom_range(99);
               if (pick < 4)       data[i] = 8'h00;
               else if (pick < 8)  data[i] = 8'hFF;
               else if (pick < 11) data[i] = 8'h80;
               else if (pick < 14) data[i] = 8'h7F;
               else                data[i] = ByteWidth'($urandom);
            end
            flip = ($urandom_range(99) < 85) ? 8'h00 : ByteWidth'($urandom_range(1, 255));
            queue_frame(kind, data, flip);
            count += FrameLen;
         end else begin
            // Noise between frames; a stray header opens a broken frame
            repeat ($urandom_range(1, 4)) begin
               pending_bytes.push_back(($urandom_range(9) == 0) ? HeaderByte
                                                                 : ByteWidth'($urandom));
               count++;
            end
         end
      end
   endtask

   // Hold until every queued byte is sent and every expected result has come back
   task automatic drain;
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   // Byte sender: hold a stalled item, otherwise send or idle at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid   <= 1'b1;
         req_rx_byte <= pending_bytes.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Track accepted bytes, check accepted results, watch for a hang
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            track_frame_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected result: roll %0d pitch %0d yaw %0d fourth %0d",
                      rsp_roll_raw, rsp_pitch_raw, rsp_yaw_raw, rsp_fourth_word_raw);
               error_count++;
            end else begin
               angle_set_type exp_set;
               exp_set = expected_angles.pop_front();
               if (rsp_roll_raw !== exp_set.roll) begin
                  $error("roll_raw: expected %0d, got %0d", exp_set.roll, rsp_roll_raw);
                  error_count++;
               end
               if (rsp_pitch_raw !== exp_set.pitch) begin
                  $error("pitch_raw: expected %0d, got %0d", exp_set.pitch, rsp_pitch_raw);
                  error_count++;
               end
               if (rsp_yaw_raw !== exp_set.yaw) begin
                  $error("yaw_raw: expected %0d, got %0d", exp_set.yaw, rsp_yaw_raw);
                  error_count++;
               end
               if (rsp_fourth_word_raw !== exp_set.fourth) begin
                  $error("fourth_word_raw: expected %0d, got %0d",
                         exp_set.fourth, rsp_fourth_word_raw);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus: directed frames, then three random phases with different idling
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = '0;
      rsp_stall     = 1'b0;
      req_taken     = 1'b0;
      frame_pos     = PosHeader;
      frame_sum     = '0;
      quiet_cycles  = 0;
      error_count   = 0;
      send_idle_pct = 23;
      recv_idle_pct = 60;
      foreach (frame_buf[i]) frame_buf[i] = '0;

      // Drop a stray byte while idle
      pending_bytes.push_back(8'hAA);
      // Good frame: extreme words, a header value inside the data
      queue_frame(TypeByte, '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h55, 8'h00, 8'hFF, 8'hFF},
                  8'h00);
      // Wrong frame type
      queue_frame(8'h54, '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88}, 8'h00);
      // Checksum mismatch
      queue_frame(TypeByte, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08},
                  8'h01);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait until every directed byte is sent and every result is back, then start random traffic
      drain();
      queue_random_stream(620);
      drain();

      send_idle_pct = 60;
      recv_idle_pct = 23;
      queue_random_stream(650);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_stream(650);
      drain();
      repeat (DrainWait) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : imu_angle_frame_parser_unit_tb

`default_nettype wire
